// File: sv/kslp_pkg.sv
// ----------------------------------------------------------------------------
// kslp_pkg: shared types and constants for the keypad scanner
// Key code table, lockout reset value, field widths and the encoder result.
// ----------------------------------------------------------------------------
package kslp_pkg;

    localparam int KEY_W     = 4;
    localparam int COUNT_W   = 16;
    localparam int COLS      = 3;
    localparam int ROWS      = 4;
    localparam int NUM_KEYS  = ROWS * COLS;

    localparam logic [COUNT_W-1:0] LOCKOUT_RESET = 16'd20000;
    localparam logic [KEY_W-1:0]   KEY_PREFIX    = 4'd11;

    // Key codes in scan order, row 1 column 1 at index 0.
    // Row 4 carries the star (10), zero and pound (11) keys.
    localparam logic [NUM_KEYS-1:0][KEY_W-1:0] KEY_TABLE = {
        4'd11, 4'd0, 4'd10,
        4'd9,  4'd8, 4'd7,
        4'd6,  4'd5, 4'd4,
        4'd3,  4'd2, 4'd1
    };

    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] code;
    } t_key_hit;

endpackage

// File: sv/kslp_encode.sv
// ----------------------------------------------------------------------------
// kslp_encode: keypad snapshot encoder
// Finds the last pressed key in scan order and returns its code.
// ----------------------------------------------------------------------------
module kslp_encode
    import kslp_pkg::*;
(
    input  logic [NUM_KEYS-1:0] i_keys,
    output t_key_hit            o_hit
);

    always_comb begin
        o_hit = '0;
        // A later key in scan order overrides an earlier one.
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (i_keys[i]) begin
                o_hit.hit  = 1'b1;
                o_hit.code = KEY_TABLE[i[3:0]];
            end
        end
    end

endmodule

// File: sv/keypad_scan_lockout_prefix.sv
// Each accepted input item gives one result item via the output stage.
// Throughput: one item per cycle with an empty skid entry; the state
// update and key encode fit between state and two-entry output registers.
// Reset: synchronous, active low; scanning enabled, no lockout, keys and
// prefix cleared, lockout register back to 20000 ticks.
// ----------------------------------------------------------------------------
// keypad_scan_lockout_prefix: 4x3 keypad scanner with lockout and prefix
// Each input item is one timer tick with a full keypad snapshot. A press
// captures the key and starts a lockout; at its end the key is reported.
// A reported key 11 arms a prefix that latches the next reported key.
// ----------------------------------------------------------------------------
module keypad_scan_lockout_prefix
    import kslp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Lockout register write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // Tick input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] row_one_columns, [5:3] row_two_columns,
    // [8:6] row_three_columns, [11:9] row_four_columns, [15:12] zero
    input  logic [15:0] s_axis_tdata,
    // Result output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] key_code, [7:4] selected_value, [8] prefix_pending,
    // [9] scanning, [15:10] zero
    output logic [15:0] m_axis_tdata,
    // [0] key_reported
    output logic        m_axis_tuser
);

    localparam int OUT_W = 17;

    // Architectural state. The model's "load" phase is always consumed in
    // the same tick it is entered, so only idle and counting remain; the
    // scan enable is simply the inverse of counting.
    logic [COUNT_W-1:0] r_lockout, n_lockout;
    logic               r_counting, n_counting;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [KEY_W-1:0]   r_captured, n_captured;
    logic [KEY_W-1:0]   r_reported, n_reported;
    logic               r_prefix, n_prefix;
    logic [KEY_W-1:0]   r_latched, n_latched;

    // Output stage: main register plus one skid entry so that a new tick
    // is taken while a finished result still waits on the master side.
    logic               r_out_valid, n_out_valid;
    logic [OUT_W-1:0]   r_out_data, n_out_data;
    logic               r_skid_valid, n_skid_valid;
    logic [OUT_W-1:0]   r_skid_data, n_skid_data;

    logic               in_accept;
    logic               out_pop;
    logic               report;
    logic [COUNT_W-1:0] count_dec;
    logic [OUT_W-1:0]   result;
    t_key_hit           key_hit;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_pop       = r_out_valid && m_axis_tready;

    kslp_encode u_encode (
        .i_keys (s_axis_tdata[NUM_KEYS-1:0]),
        .o_hit  (key_hit)
    );

    assign count_dec = r_count - 1'b1;

    always_comb begin
        n_lockout  = r_lockout;
        n_counting = r_counting;
        n_count    = r_count;
        n_captured = r_captured;
        n_reported = r_reported;
        n_prefix   = r_prefix;
        n_latched  = r_latched;
        report     = 1'b0;

        if (i_cfg_valid) begin
            n_lockout = i_cfg_data;
        end

        if (in_accept) begin
            if (!r_counting && key_hit.hit) begin
                // A press captures the key and loads the lockout counter.
                n_captured = key_hit.code;
                n_counting = 1'b1;
                n_count    = r_lockout;
            end else if (r_counting) begin
                // A zero lockout wraps here, giving 65536 ticks.
                n_count = count_dec;
                if (count_dec == '0) begin
                    report     = 1'b1;
                    n_counting = 1'b0;
                    n_reported = r_captured;
                end
            end

            if (report) begin
                if (r_prefix) begin
                    n_latched = r_captured;
                    n_prefix  = 1'b0;
                end
                if (r_captured == KEY_PREFIX) begin
                    n_prefix = 1'b1;
                end
            end
        end
    end

    // Result item: {key_reported, zero pad, scanning, prefix, selected, key}.
    assign result = {report, 6'd0, !n_counting, n_prefix, n_latched, n_reported};

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;

        priority if (r_skid_valid) begin
            if (out_pop) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_pop) begin
                n_out_valid = 1'b1;
                n_out_data  = result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = result;
            end
        end else if (out_pop) begin
            n_out_valid = 1'b0;
        end else begin
            // Nothing moves, so the stage holds its contents.
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout    <= LOCKOUT_RESET;
            r_counting   <= 1'b0;
            r_count      <= '0;
            r_captured   <= '0;
            r_reported   <= '0;
            r_prefix     <= 1'b0;
            r_latched    <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_lockout    <= n_lockout;
            r_counting   <= n_counting;
            r_count      <= n_count;
            r_captured   <= n_captured;
            r_reported   <= n_reported;
            r_prefix     <= n_prefix;
            r_latched    <= n_latched;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data[15:0];
    assign m_axis_tuser  = r_out_data[16];

`ifndef ASSERT_OFF
    // The skid entry is only ever filled behind a held output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // A reported key always ends the lockout, so scanning must be back on.
    a_report_scanning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[9])
        else $error("key reported while scanning is still off");

    // An accepted press while idle must start a lockout.
    a_press_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !r_counting && key_hit.hit) |=> r_counting)
        else $error("key press did not start the lockout");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the keypad scanner with lockout
// Feeds timer ticks with keypad snapshots through the input stream, predicts
// every result item, and compares each field of each result as it arrives.
// It covers a register write during a lockout, the shortest lockout, and
// random key sequences with prefix keys under several lockout settings.
// ----------------------------------------------------------------------------
module testbench
    import kslp_pkg::*;
();

    localparam int          STALL_LIMIT = 2000;  // cycles with no item moving
    localparam int          PRINT_LIMIT = 20;
    localparam logic [3:0]  STAR_KEY    = 4'd10;
    localparam logic [3:0]  POUND_KEY   = 4'd11;

    // Lockout sequencer of the scanner, as the predictor keeps it.
    typedef enum logic [1:0] {
        LOCK_LOAD  = 2'd0,
        LOCK_COUNT = 2'd1,
        LOCK_IDLE  = 2'd2
    } t_lock_step;

    // One result item, split into its fields.
    typedef struct packed {
        logic       reported;
        logic       scanning;
        logic       prefix;
        logic [3:0] selected;
        logic [3:0] code;
    } t_key_result;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data    = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    keypad_scan_lockout_prefix uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Snapshots waiting to be sent, and results the scanner still owes us.
    logic [11:0] pending_ticks[$];
    t_key_result expected_results[$];

    // Predictor state. Only the monitor block changes it.
    logic [15:0] lockout_setting = LOCKOUT_RESET;
    logic        scan_on         = 1'b1;
    t_lock_step  lock_step       = LOCK_IDLE;
    logic [15:0] lock_left       = 16'd0;
    logic [3:0]  held_key        = 4'd0;
    logic [3:0]  shown_key       = 4'd0;
    logic        prefix_armed    = 1'b0;
    logic [3:0]  chosen_key      = 4'd0;

    logic        tick_taken = 1'b0;  // input item accepted at the last rising edge
    logic        steady     = 1'b0;  // when set, neither side idles
    int          mismatch_count = 0;
    int          ticks_sent     = 0;
    int          results_seen   = 0;
    int          keys_reported  = 0;
    int          prefix_latches = 0;
    int          cfg_writes     = 0;
    int          idle_cycles    = 0;

    // Snapshot bit r*3+c stands for row r+1, column c+1. Rows one to three
    // carry the digits; the bottom row is star, zero and pound.
    function automatic logic [3:0] key_at(input int pos);
        case (pos)
            9:       return STAR_KEY;
            10:      return 4'd0;
            11:      return POUND_KEY;
            default: return 4'(pos + 1);
        endcase
    endfunction

    // Advances the predicted scanner by one tick and gives the result item.
    task automatic step_keypad(input logic [11:0] snap, output t_key_result res);
        logic reported;
        reported = 1'b0;
        // Scan order is row by row, column by column; the last press found wins.
        if (scan_on) begin
            for (int pos = 0; pos < 12; pos++) begin
                if (snap[pos]) begin
                    held_key  = key_at(pos);
                    scan_on   = 1'b0;
                    lock_step = LOCK_LOAD;
                end
            end
        end
        case (lock_step)
            LOCK_LOAD: begin
                lock_left = lockout_setting;
                lock_step = LOCK_COUNT;
            end
            LOCK_COUNT: begin
                // A zero setting wraps here, so the lockout lasts 65536 ticks.
                lock_left = lock_left - 16'd1;
                if (lock_left == 16'd0) begin
                    scan_on   = 1'b1;
                    shown_key = held_key;
                    reported  = 1'b1;
                    lock_step = LOCK_IDLE;
                end
            end
            default: ;
        endcase
        if (reported) begin
            if (prefix_armed) begin
                chosen_key   = shown_key;
                prefix_armed = 1'b0;
                prefix_latches++;
            end
            // A pound key arms the prefix again, even right after latching.
            if (shown_key == POUND_KEY)
                prefix_armed = 1'b1;
        end
        res.reported = reported;
        res.scanning = scan_on;
        res.prefix   = prefix_armed;
        res.selected = chosen_key;
        res.code     = shown_key;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: result %0d, %s: got %0d, want %0d",
                     $realtime, results_seen, what, got, want);
    endtask

    // Driver: new input items and the output ready change at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= steady || ($urandom_range(99) >= 6);
            if (!s_axis_tvalid || tick_taken) begin
                if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0000, pending_ticks.pop_front()};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: handshakes are sampled at the rising edge, before any output
    // of the scanner moves. Predictions are made as input items go in.
    t_key_result want_result;
    t_key_result got_result;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_taken <= 1'b0;
        end else begin
            tick_taken <= s_axis_tvalid && s_axis_tready;
            if (i_cfg_valid && o_cfg_ready) begin
                lockout_setting = i_cfg_data;
                cfg_writes++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                step_keypad(s_axis_tdata[11:0], want_result);
                expected_results.push_back(want_result);
                ticks_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_result.reported = m_axis_tuser;
                got_result.scanning = m_axis_tdata[9];
                got_result.prefix   = m_axis_tdata[8];
                got_result.selected = m_axis_tdata[7:4];
                got_result.code     = m_axis_tdata[3:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", m_axis_tdata, 0);
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result.reported != want_result.reported)
                        report_mismatch("key_reported", got_result.reported,
                                        want_result.reported);
                    if (got_result.code != want_result.code)
                        report_mismatch("key_code", got_result.code, want_result.code);
                    if (got_result.selected != want_result.selected)
                        report_mismatch("selected_value", got_result.selected,
                                        want_result.selected);
                    if (got_result.prefix != want_result.prefix)
                        report_mismatch("prefix_pending", got_result.prefix,
                                        want_result.prefix);
                    if (got_result.scanning != want_result.scanning)
                        report_mismatch("scanning", got_result.scanning,
                                        want_result.scanning);
                end
                results_seen++;
                if (got_result.reported)
                    keys_reported++;
            end
        end
    end

    // Watchdog: a run in which no item moves for too long has hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Holds the sender back until every queued tick has gone in and every
    // result it caused has come out.
    task automatic wait_for_idle();
        while (pending_ticks.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Writes the lockout register while nothing is in flight. The scanner may
    // still be counting down; the new value only applies to the next press.
    task automatic write_lockout(input logic [15:0] ticks);
        wait_for_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Keys pressed, released or bouncing while the scanner is locked out.
    function automatic logic [11:0] noise_snapshot();
        return ($urandom_range(1) == 0) ? 12'd0 : 12'($urandom);
    endfunction

    task automatic queue_lockout_fill(input int count);
        repeat (count) pending_ticks.push_back(noise_snapshot());
    endtask

    // Random key sequences: a press, a lockout full of noise that ends on the
    // report tick, then a few quiet ticks. Pound is favored so that prefixes
    // are armed often. Some presses carry extra keys earlier in scan order,
    // which the later key overrides. Now and then a stray snapshot goes in.
    task automatic queue_key_sequences(input int lock, input int count);
        int          queued;
        int          key_pos;
        int          quiet;
        logic [11:0] snap;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(9) == 0) begin
                pending_ticks.push_back(12'($urandom));
                queued++;
            end else begin
                key_pos = ($urandom_range(3) == 0) ? 11 : $urandom_range(11);
                snap    = 12'd1 << key_pos;
                if ($urandom_range(3) == 0)
                    snap = snap | (12'($urandom) & (snap - 12'd1));
                pending_ticks.push_back(snap);
                queue_lockout_fill(lock);
                quiet = $urandom_range(2);
                repeat (quiet) pending_ticks.push_back(12'd0);
                queued += 1 + lock + quiet;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A 40 tick lockout. Every key at once must capture pound, the last
        // key in scan order.
        write_lockout(16'd40);
        pending_ticks.push_back(12'd0);
        pending_ticks.push_back(12'hFFF);
        queue_lockout_fill(15);
        // Change the register in the middle of this lockout; the count that
        // is running must not change.
        write_lockout(16'd1);
        queue_lockout_fill(25);
        pending_ticks.push_back(12'd0);

        // Shortest lockout: every key alone, then pound twice in a row so a
        // pending prefix latches pound and arms itself again.
        for (int pos = 0; pos < 12; pos++) begin
            pending_ticks.push_back(12'd1 << pos);
            pending_ticks.push_back(12'd0);
        end
        pending_ticks.push_back(12'd1 << 11);
        pending_ticks.push_back(12'd0);

        // Random sequences under several settings; one stretch runs with
        // neither side idling.
        queue_key_sequences(1, 130);
        write_lockout(16'd2);
        queue_key_sequences(2, 170);
        write_lockout(16'd5);
        steady = 1'b1;
        queue_key_sequences(5, 170);
        wait_for_idle();
        steady = 1'b0;
        write_lockout(16'd3);
        queue_key_sequences(3, 130);
        write_lockout(16'($urandom_range(4, 12)));
        queue_key_sequences(int'(lockout_setting), 90);

        // Drain, then give the output stage time to show any stray result.
        wait_for_idle();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d ticks with %0d register writes; %0d results checked.",
                 ticks_sent, cfg_writes, results_seen);
        $display("Keys reported: %0d, prefix latches: %0d, mismatches: %0d.",
                 keys_reported, prefix_latches, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
